FILE: hw/rtl/dfc_pkg.sv
// shared types and constants of the datagram frame checker
package dfc_pkg;

   localparam int MaxPayload = 64;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic       ModeHeader  = 1'b0;
   localparam logic [6:0] CheckOffset = 7'd32;

   typedef enum logic [1:0] {
      ST_DELIVERED = 2'd0,
      ST_LOST      = 2'd1,
      ST_BAD_CHECK = 2'd2,
      ST_OUT_ORDER = 2'd3
   } status_type;

   // finished frame handed from the front to the back
   typedef struct packed {
      logic [7:0] seq;
      logic [7:0] rx_check;
      logic       drop;
      logic [6:0] calc;
   } frame_type;

endpackage

FILE: hw/rtl/dfc_front.sv
// frame assembly: header capture, payload sum and frame end detection
module dfc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                mode,
   input  logic [7:0]          frame_seq,
   input  logic [7:0]          frame_kind,
   input  logic [6:0]          payload_len,
   input  logic [7:0]          rx_checksum,
   input  logic                drop_flag,
   input  logic [7:0]          payload_byte,
   output logic                push,
   output dfc_pkg::frame_type  push_frame
);
   import dfc_pkg::*;

   logic       open_ff, open_in;
   logic [7:0] seq_ff, seq_in;
   logic [7:0] check_ff, check_in;
   logic       drop_ff, drop_in;
   logic [6:0] left_ff, left_in;
   logic [5:0] sum_ff, sum_in;

   logic [6:0] len_sat;
   logic [5:0] hdr_sum;
   logic [5:0] pay_sum;

   assign len_sat = (payload_len > 7'(MaxPayload)) ? 7'(MaxPayload) : payload_len;
   assign hdr_sum = frame_seq[5:0] + frame_kind[5:0] + len_sat[5:0];
   assign pay_sum = sum_ff + payload_byte[5:0];

   always_comb begin
      open_in    = open_ff;
      seq_in     = seq_ff;
      check_in   = check_ff;
      drop_in    = drop_ff;
      left_in    = left_ff;
      sum_in     = sum_ff;
      push       = 1'b0;
      push_frame = '0;
      if (accept) begin
         if (mode == ModeHeader) begin
            // a new header abandons any open frame
            seq_in   = frame_seq;
            check_in = rx_checksum;
            drop_in  = drop_flag;
            left_in  = len_sat;
            sum_in   = hdr_sum;
            open_in  = (len_sat != 7'd0);
            push     = (len_sat == 7'd0);
            push_frame.seq      = frame_seq;
            push_frame.rx_check = rx_checksum;
            push_frame.drop     = drop_flag;
            push_frame.calc     = 7'(hdr_sum) + CheckOffset;
         end else if (open_ff) begin
            sum_in  = pay_sum;
            left_in = left_ff - 7'd1;
            if (left_ff == 7'd1) begin
               open_in = 1'b0;
               push    = 1'b1;
            end
            push_frame.seq      = seq_ff;
            push_frame.rx_check = check_ff;
            push_frame.drop     = drop_ff;
            push_frame.calc     = 7'(pay_sum) + CheckOffset;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 1'b0;
         left_ff <= '0;
      end else begin
         open_ff <= open_in;
         left_ff <= left_in;
      end
      seq_ff   <= seq_in;
      check_ff <= check_in;
      drop_ff  <= drop_in;
      sum_ff   <= sum_in;
   end

endmodule

FILE: hw/rtl/dfc_queue.sv
// short queue of finished frames between front and back
module dfc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dfc_pkg::frame_type  push_frame,
   input  logic                pop,
   output logic                head_valid,
   output dfc_pkg::frame_type  head_frame,
   output logic                full
);
   import dfc_pkg::*;

   frame_type               slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]    count_ff, count_in;
   logic                    do_push, do_pop;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_frame = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QueueCntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

endmodule

FILE: hw/rtl/dfc_back.sv
// verdict, sequence tracking, counters and result register
module dfc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  dfc_pkg::frame_type  head_frame,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic                rsp_delivered,
   output logic [7:0]          rsp_done_seq,
   output logic [7:0]          rsp_next_expected,
   output logic [6:0]          rsp_sum_check,
   output logic [31:0]         rsp_good_count,
   output logic [31:0]         rsp_lost_count,
   output logic [31:0]         rsp_resend_count
);
   import dfc_pkg::*;

   logic [7:0]  expect_ff, expect_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] lost_ff, lost_in;
   logic [31:0] resend_ff, resend_in;
   logic        valid_ff, valid_in;
   status_type  status_ff, status_in;
   logic [7:0]  seq_ff;
   logic [6:0]  calc_ff;

   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      expect_in = expect_ff;
      good_in   = good_ff;
      lost_in   = lost_ff;
      resend_in = resend_ff;
      status_in = status_ff;
      valid_in  = valid_ff && rsp_stall;
      if (pop) begin
         valid_in = 1'b1;
         if (head_frame.drop) begin
            status_in = ST_LOST;
            lost_in   = lost_ff + 32'd1;
            resend_in = resend_ff + 32'd1;
         end else if (head_frame.rx_check != {1'b0, head_frame.calc}) begin
            status_in = ST_BAD_CHECK;
            lost_in   = lost_ff + 32'd1;
            resend_in = resend_ff + 32'd1;
         end else if (head_frame.seq != expect_ff) begin
            status_in = ST_OUT_ORDER;
            resend_in = resend_ff + 32'd1;
         end else begin
            status_in = ST_DELIVERED;
            good_in   = good_ff + 32'd1;
            expect_in = expect_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         expect_ff <= '0;
         good_ff   <= '0;
         lost_ff   <= '0;
         resend_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         expect_ff <= expect_in;
         good_ff   <= good_in;
         lost_ff   <= lost_in;
         resend_ff <= resend_in;
      end
      status_ff <= status_in;
      if (pop) begin
         seq_ff  <= head_frame.seq;
         calc_ff <= head_frame.calc;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_delivered     = (status_ff == ST_DELIVERED);
   assign rsp_done_seq      = seq_ff;
   assign rsp_next_expected = expect_ff;
   assign rsp_sum_check     = calc_ff;
   assign rsp_good_count    = good_ff;
   assign rsp_lost_count    = lost_ff;
   assign rsp_resend_count  = resend_ff;

endmodule

FILE: hw/rtl/datagram_frame_checker.sv
// datagram frame checker: top level joining front, frame queue and back
// a finished frame passes through the frame queue and then the result register before it shows on rsp_valid
// throughput: one input transaction per cycle while req_stall is low; the front only adds into a six-bit sum
// the front stalls only while the four-entry frame queue is full
// reset (synchronous, active high) clears the open frame, the queue, sequence and counters
// no clearing pass: the block takes transactions as soon as reset is released
module datagram_frame_checker (
   input  logic        clock,
   input  logic        reset,
   // request channel: one header or payload transaction
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_frame_seq,
   input  logic [7:0]  req_frame_kind,
   input  logic [6:0]  req_payload_len,
   input  logic [7:0]  req_rx_checksum,
   input  logic        req_drop_flag,
   input  logic [7:0]  req_payload_byte,
   // response channel: one transaction per finished frame
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_delivered,
   output logic [7:0]  rsp_done_seq,
   output logic [7:0]  rsp_next_expected,
   output logic [6:0]  rsp_sum_check,
   output logic [31:0] rsp_good_count,
   output logic [31:0] rsp_lost_count,
   output logic [31:0] rsp_resend_count
);
   import dfc_pkg::*;

   logic      req_accept;
   logic      push;
   frame_type push_frame;
   logic      pop;
   logic      head_valid;
   frame_type head_frame;
   logic      queue_full;

   // stall depends only on registered queue occupancy, never on rsp_stall
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // front: captures headers, sums payload bytes, detects frame end
   dfc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .mode         (req_mode),
      .frame_seq    (req_frame_seq),
      .frame_kind   (req_frame_kind),
      .payload_len  (req_payload_len),
      .rx_checksum  (req_rx_checksum),
      .drop_flag    (req_drop_flag),
      .payload_byte (req_payload_byte),
      .push         (push),
      .push_frame   (push_frame)
   );

   // finished frames wait here so either side can stall on its own
   dfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .pop        (pop),
      .head_valid (head_valid),
      .head_frame (head_frame),
      .full       (queue_full)
   );

   // back: drop, checksum, sequence checks in that order, then counters
   dfc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_frame        (head_frame),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_delivered     (rsp_delivered),
      .rsp_done_seq      (rsp_done_seq),
      .rsp_next_expected (rsp_next_expected),
      .rsp_sum_check     (rsp_sum_check),
      .rsp_good_count    (rsp_good_count),
      .rsp_lost_count    (rsp_lost_count),
      .rsp_resend_count  (rsp_resend_count)
   );

endmodule

FILE: dv/frame_verdict_pkg.sv
// scoreboard of the datagram frame checker: transaction types, frame predictor, verdict check
package frame_verdict_pkg;

   import dfc_pkg::*;

   typedef struct {
      logic       mode;
      logic [7:0] frame_seq;
      logic [7:0] frame_kind;
      logic [6:0] payload_len;
      logic [7:0] rx_checksum;
      logic       drop_flag;
      logic [7:0] payload_byte;
   } frame_item_type;

   typedef struct {
      status_type  status;
      logic        delivered;
      logic [7:0]  done_seq;
      logic [7:0]  next_expected;
      logic [6:0]  sum_check;
      logic [31:0] good_count;
      logic [31:0] lost_count;
      logic [31:0] resend_count;
   } frame_verdict_type;

   class frame_verdict_sb;
      int unsigned       mismatches;
      int unsigned       verdicts_seen;
      frame_verdict_type verdict_q[$];

      // shadow of the checker state
      logic [7:0]  expect_seq;
      logic [31:0] good_total;
      logic [31:0] lost_total;
      logic [31:0] resend_total;
      logic        frame_open;
      logic [7:0]  held_seq;
      logic [7:0]  held_check;
      logic        held_drop;
      logic [6:0]  bytes_left;
      logic [5:0]  running_sum;

      function new();
         mismatches    = 0;
         verdicts_seen = 0;
         expect_seq    = '0;
         good_total    = '0;
         lost_total    = '0;
         resend_total  = '0;
         frame_open    = 1'b0;
         held_seq      = '0;
         held_check    = '0;
         held_drop     = 1'b0;
         bytes_left    = '0;
         running_sum   = '0;
      endfunction

      // drop first, then checksum, then sequence
      function void settle_frame();
         frame_verdict_type v;
         logic [6:0]        calc;
         calc = {1'b0, running_sum} + CheckOffset;
         if (held_drop) begin
            v.status = ST_LOST;
            lost_total++;
            resend_total++;
         end else if (held_check != {1'b0, calc}) begin
            v.status = ST_BAD_CHECK;
            lost_total++;
            resend_total++;
         end else if (held_seq != expect_seq) begin
            v.status = ST_OUT_ORDER;
            resend_total++;
         end else begin
            v.status = ST_DELIVERED;
            good_total++;
            expect_seq++;
         end
         frame_open      = 1'b0;
         bytes_left      = '0;
         v.delivered     = (v.status == ST_DELIVERED);
         v.done_seq      = held_seq;
         v.next_expected = expect_seq;
         v.sum_check     = calc;
         v.good_count    = good_total;
         v.lost_count    = lost_total;
         v.resend_count  = resend_total;
         verdict_q.push_back(v);
      endfunction

      function void absorb_item(frame_item_type it);
         logic [6:0] len;
         if (it.mode == ModeHeader) begin
            // a new header drops any unfinished frame
            len = (it.payload_len > MaxPayload) ? 7'(MaxPayload) : it.payload_len;
            held_seq    = it.frame_seq;
            held_check  = it.rx_checksum;
            held_drop   = it.drop_flag;
            bytes_left  = len;
            running_sum = 6'(it.frame_seq + it.frame_kind + len);
            frame_open  = 1'b1;
            if (bytes_left == 0) settle_frame();
         end else if (frame_open) begin
            running_sum = running_sum + it.payload_byte[5:0];
            bytes_left--;
            if (bytes_left == 0) settle_frame();
         end
      endfunction

      task report(string msg);
         mismatches++;
         if (mismatches <= 100) $display("%0t mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("verdict %0d %s got %0h want %0h", verdicts_seen, name, got, want));
      endtask

      task check_verdict(frame_verdict_type got);
         frame_verdict_type want;
         if (verdict_q.size() == 0) begin
            report($sformatf("verdict %0d arrived with no frame pending", verdicts_seen));
         end else begin
            want = verdict_q.pop_front();
            compare_field("status", got.status, want.status);
            compare_field("delivered", got.delivered, want.delivered);
            compare_field("done_seq", got.done_seq, want.done_seq);
            compare_field("next_expected", got.next_expected, want.next_expected);
            compare_field("sum_check", got.sum_check, want.sum_check);
            compare_field("good_count", got.good_count, want.good_count);
            compare_field("lost_count", got.lost_count, want.lost_count);
            compare_field("resend_count", got.resend_count, want.resend_count);
         end
         verdicts_seen++;
      endtask
   endclass

endpackage

FILE: dv/tb_top.sv
// top of the datagram frame checker testbench: clock, reset, drivers, monitors and watchdog
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dfc_pkg::*;
   import frame_verdict_pkg::*;

   localparam logic ModePayload   = ~ModeHeader;
   // legal quiet stretches are short random gaps or stall runs
   localparam int   WatchdogLimit = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic        req_mode         = 1'b0;
   logic [7:0]  req_frame_seq    = '0;
   logic [7:0]  req_frame_kind   = '0;
   logic [6:0]  req_payload_len  = '0;
   logic [7:0]  req_rx_checksum  = '0;
   logic        req_drop_flag    = 1'b0;
   logic [7:0]  req_payload_byte = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_delivered;
   logic [7:0]  rsp_done_seq;
   logic [7:0]  rsp_next_expected;
   logic [6:0]  rsp_sum_check;
   logic [31:0] rsp_good_count;
   logic [31:0] rsp_lost_count;
   logic [31:0] rsp_resend_count;

   frame_verdict_sb sb;

   // idling percentages of the current phase
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   int unsigned idle_tab[4]   = '{0, 69, 0, 26};
   int unsigned stall_tab[4]  = '{0, 0, 69, 26};

   int unsigned items_sent    = 0;
   int unsigned quiet_cycles  = 0;
   // sequence the generator means its next good frame to carry
   logic [7:0]  next_good_seq = '0;

   frame_item_type    seen_item;
   frame_verdict_type seen_verdict;

   datagram_frame_checker DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_frame_seq     (req_frame_seq),
      .req_frame_kind    (req_frame_kind),
      .req_payload_len   (req_payload_len),
      .req_rx_checksum   (req_rx_checksum),
      .req_drop_flag     (req_drop_flag),
      .req_payload_byte  (req_payload_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_delivered     (rsp_delivered),
      .rsp_done_seq      (rsp_done_seq),
      .rsp_next_expected (rsp_next_expected),
      .rsp_sum_check     (rsp_sum_check),
      .rsp_good_count    (rsp_good_count),
      .rsp_lost_count    (rsp_lost_count),
      .rsp_resend_count  (rsp_resend_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls at random, at the rate of the phase
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // monitors: the input transaction is noted before the verdict is checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen_item.mode         = req_mode;
            seen_item.frame_seq    = req_frame_seq;
            seen_item.frame_kind   = req_frame_kind;
            seen_item.payload_len  = req_payload_len;
            seen_item.rx_checksum  = req_rx_checksum;
            seen_item.drop_flag    = req_drop_flag;
            seen_item.payload_byte = req_payload_byte;
            sb.absorb_item(seen_item);
         end
         if (rsp_valid && !rsp_stall) begin
            seen_verdict.status        = status_type'(rsp_status);
            seen_verdict.delivered     = rsp_delivered;
            seen_verdict.done_seq      = rsp_done_seq;
            seen_verdict.next_expected = rsp_next_expected;
            seen_verdict.sum_check     = rsp_sum_check;
            seen_verdict.good_count    = rsp_good_count;
            seen_verdict.lost_count    = rsp_lost_count;
            seen_verdict.resend_count  = rsp_resend_count;
            sb.check_verdict(seen_verdict);
         end
      end
   end

   // watchdog: too long with no transaction on either channel means a hang
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WatchdogLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // every field random, callers pin down the ones that matter
   function automatic frame_item_type random_item();
      frame_item_type it;
      it.mode         = 1'($urandom_range(1));
      it.frame_seq    = 8'($urandom_range(255));
      it.frame_kind   = 8'($urandom_range(255));
      it.payload_len  = 7'($urandom_range(127));
      it.rx_checksum  = 8'($urandom_range(255));
      it.drop_flag    = 1'($urandom_range(1));
      it.payload_byte = 8'($urandom_range(255));
      return it;
   endfunction

   // one transaction: random idle gap, then hold until accepted
   task automatic send_item(input frame_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= it.mode;
      req_frame_seq    <= it.frame_seq;
      req_frame_kind   <= it.frame_kind;
      req_payload_len  <= it.payload_len;
      req_rx_checksum  <= it.rx_checksum;
      req_drop_flag    <= it.drop_flag;
      req_payload_byte <= it.payload_byte;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // header plus n_sent payload bytes; fill below zero means random bytes
   task automatic send_frame(input logic [7:0] seq, input logic [7:0] kind,
                             input logic [6:0] len, input bit good_check, input bit drop,
                             input int n_sent, input int fill);
      logic [7:0]     data_q[$];
      frame_item_type it;
      int             count;
      int             frame_sum;
      logic [7:0]     right_check;
      count     = (len > MaxPayload) ? MaxPayload : len;
      frame_sum = seq + kind + count;
      for (int i = 0; i < count; i++) begin
         data_q.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
         frame_sum += data_q[i];
      end
      right_check = 8'((frame_sum & 'h3F) + CheckOffset);
      it             = random_item();
      it.mode        = ModeHeader;
      it.frame_seq   = seq;
      it.frame_kind  = kind;
      it.payload_len = len;
      it.drop_flag   = drop;
      it.rx_checksum = right_check;
      if (!good_check) begin
         while (it.rx_checksum == right_check) it.rx_checksum = 8'($urandom_range(255));
      end
      send_item(it);
      for (int i = 0; i < n_sent; i++) begin
         it              = random_item();
         it.mode         = ModePayload;
         it.payload_byte = data_q[i];
         send_item(it);
      end
   endtask

   // payload transactions with no frame open
   task automatic send_stray(input int n);
      frame_item_type it;
      for (int i = 0; i < n; i++) begin
         it      = random_item();
         it.mode = ModePayload;
         send_item(it);
      end
   endtask

   // sender holds off until every verdict has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.verdict_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned phase_end;
      int unsigned pick;
      int unsigned r;
      int          count;
      logic [6:0]  len;
      logic [7:0]  seq;
      logic [7:0]  kind;
      bit          left_open;
      left_open = 1'b0;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_tab[ph];
         stall_pct     = stall_tab[ph];

         if (ph == 0) begin
            // stray payload straight after reset
            send_stray(1);
            // zero length frames: delivered, lost, bad checksum, out of order
            send_frame(8'h00, 8'h00, 7'd0, 1'b1, 1'b0, 0, -1);
            send_frame(8'h01, 8'hFF, 7'd0, 1'b1, 1'b1, 0, -1);
            send_frame(8'h01, 8'h5A, 7'd0, 1'b0, 1'b0, 0, -1);
            send_frame(8'hFF, 8'hFF, 7'd0, 1'b1, 1'b0, 0, -1);
            // payload byte extremes
            send_frame(8'h01, 8'hFF, 7'd2, 1'b1, 1'b0, 2, 255);
            send_frame(8'h02, 8'h00, 7'd2, 1'b1, 1'b0, 2, 0);
            // frame cut short by the next header
            send_frame(8'h03, 8'h07, 7'd3, 1'b1, 1'b0, 1, -1);
            send_frame(8'h03, 8'h00, 7'd1, 1'b1, 1'b0, 1, 8'h80);
            send_stray(2);
            // drop wins over a bad checksum, bad checksum wins over sequence
            send_frame(8'h04, 8'hAA, 7'd1, 1'b0, 1'b1, 1, -1);
            send_frame(8'h10, 8'h3C, 7'd0, 1'b0, 1'b0, 0, -1);
            next_good_seq = 8'h04;
         end

         phase_end = items_sent + 130;
         while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            r    = $urandom_range(99);
            // mostly short frames, a few at or above the payload limit
            if (r < 35)      len = 7'd0;
            else if (r < 80) len = 7'($urandom_range(6, 1));
            else if (r < 96) len = 7'($urandom_range(64, 7));
            else             len = 7'($urandom_range(127, 65));
            count = (len > MaxPayload) ? MaxPayload : len;
            kind  = 8'($urandom_range(255));
            if (pick < 94) left_open = (pick >= 86);
            if (pick < 58) begin
               // well formed, in order
               send_frame(next_good_seq, kind, len, 1'b1, 1'b0, count, -1);
               next_good_seq++;
            end else if (pick < 68) begin
               // lost on the channel
               seq = $urandom_range(1) ? next_good_seq : 8'($urandom_range(255));
               send_frame(seq, kind, len, 1'($urandom_range(1)), 1'b1, count, -1);
            end else if (pick < 78) begin
               // corrupted checksum
               send_frame(next_good_seq, kind, len, 1'b0, 1'b0, count, -1);
            end else if (pick < 86) begin
               // out of order
               seq = 8'($urandom_range(255));
               if (seq == next_good_seq) seq++;
               send_frame(seq, kind, len, 1'b1, 1'b0, count, -1);
            end else if (pick < 94) begin
               // left open, the next header abandons it
               if (len == 0) begin
                  len   = 7'($urandom_range(6, 1));
                  count = len;
               end
               send_frame(next_good_seq, kind, len, 1'b1, 1'b0, $urandom_range(count - 1, 0), -1);
            end else if (!left_open) begin
               send_stray($urandom_range(3, 1));
            end
         end
         pause_until_drained();
      end

      // let any late or extra verdict show up
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/dfc_pkg.sv
hw/rtl/dfc_front.sv
hw/rtl/dfc_queue.sv
hw/rtl/dfc_back.sv
hw/rtl/datagram_frame_checker.sv
dv/frame_verdict_pkg.sv
dv/tb_top.sv
